// ===== rtl/lenorm_pkg.sv =====
// ----------------------------------------------------------------------------
// lenorm_pkg
// Shared types and constants for the line ending normaliser.
// ----------------------------------------------------------------------------
package lenorm_pkg;

    localparam int MAX_EOL_BYTES = 8;
    localparam int LEN_W         = 4;
    // counts terminator bytes up to and including a full sequence
    localparam int IDX_W         = $clog2(MAX_EOL_BYTES + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_EOL_BYTES);
    localparam logic [LEN_W-1:0] RESET_LEN = 4'd1;
    localparam logic [63:0] RESET_EOL_BYTES = 64'd10;

    // register indexes (paddr bit 3)
    localparam logic REG_EOL_BYTES  = 1'b0;
    localparam logic REG_EOL_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_CR   = 2'd1,
        PEND_LF   = 2'd2
    } pend_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // one decoded request: terminator bytes to emit, then an optional data byte
    typedef struct packed {
        logic [LEN_W-1:0] nbytes;
        logic             pass;
        logic [7:0]       data;
    } cmd_t;

endpackage

// ===== rtl/lenorm_front.sv =====
// ----------------------------------------------------------------------------
// lenorm_front
// Classifies input requests and tracks the pending CR or LF.
// ----------------------------------------------------------------------------
module lenorm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lenorm_pkg::in_item_t          s_data,
    input  logic [lenorm_pkg::LEN_W-1:0]  brk_len,
    input  logic                          q_full,
    output logic                          q_push,
    output lenorm_pkg::cmd_t              q_cmd
);

    lenorm_pkg::pend_t pend_reg, pend_next, code;
    logic              brk;
    logic              pass;
    logic              accept;
    logic [lenorm_pkg::LEN_W-1:0] len_sat;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign len_sat = (brk_len > lenorm_pkg::MAX_LEN) ? lenorm_pkg::MAX_LEN : brk_len;

    always_comb begin
        brk       = 1'b0;
        pass      = 1'b0;
        pend_next = pend_reg;
        code      = (s_data.in_byte == lenorm_pkg::CHAR_CR) ?
                    lenorm_pkg::PEND_CR : lenorm_pkg::PEND_LF;
        if (s_data.end_of_stream) begin
            brk       = (pend_reg != lenorm_pkg::PEND_NONE);
            pend_next = lenorm_pkg::PEND_NONE;
        end else if (s_data.in_byte == lenorm_pkg::CHAR_NUL) begin
            brk = 1'b1;
        end else if (s_data.in_byte == lenorm_pkg::CHAR_CR ||
                     s_data.in_byte == lenorm_pkg::CHAR_LF) begin
            if (pend_reg == code) begin
                brk = 1'b1;
            end else if (pend_reg != lenorm_pkg::PEND_NONE) begin
                // mixed pair closes one line
                brk       = 1'b1;
                pend_next = lenorm_pkg::PEND_NONE;
            end else begin
                pend_next = code;
            end
        end else begin
            brk       = (pend_reg != lenorm_pkg::PEND_NONE);
            pend_next = lenorm_pkg::PEND_NONE;
            pass      = 1'b1;
        end
    end

    always_comb begin
        q_cmd.nbytes = brk ? len_sat : '0;
        q_cmd.pass   = pass;
        q_cmd.data   = s_data.in_byte;
        // requests that produce nothing never enter the queue
        q_push       = accept && (q_cmd.nbytes != '0 || pass);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= lenorm_pkg::PEND_NONE;
        end else if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== rtl/lenorm_queue.sv =====
// ----------------------------------------------------------------------------
// lenorm_queue
// Short command queue between the classifier and the output expander.
// ----------------------------------------------------------------------------
module lenorm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lenorm_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output lenorm_pkg::cmd_t head_cmd
);

    lenorm_pkg::cmd_t entry_reg [lenorm_pkg::QUEUE_DEPTH];
    logic [lenorm_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [lenorm_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full       = (count_reg == lenorm_pkg::QCNT_W'(lenorm_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/lenorm_back.sv =====
// ----------------------------------------------------------------------------
// lenorm_back
// Expands queued commands into output bytes, one per cycle while a command is queued and the output is not stalled.
// ----------------------------------------------------------------------------
module lenorm_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [63:0]          eol_bytes,
    input  logic                 head_valid,
    input  lenorm_pkg::cmd_t     head_cmd,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lenorm_pkg::out_item_t m_data
);

    logic [lenorm_pkg::IDX_W-1:0] idx_reg;
    logic                         m_valid_reg, m_valid_next;
    lenorm_pkg::out_item_t        m_data_reg, gen;
    logic                         load;
    logic                         emit_brk;
    logic [lenorm_pkg::LEN_W-1:0] idx_ext;

    assign idx_ext  = lenorm_pkg::LEN_W'(idx_reg);
    assign emit_brk = (idx_ext < head_cmd.nbytes);
    assign load     = head_valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (emit_brk) begin
            gen.out_byte = eol_bytes[{idx_reg[lenorm_pkg::IDX_W-2:0], 3'b000} +: 8];
            gen.last     = (idx_ext == head_cmd.nbytes - 1'b1) && !head_cmd.pass;
        end else begin
            gen.out_byte = head_cmd.data;
            gen.last     = 1'b1;
        end
    end

    // the command leaves the queue with its final byte
    assign pop = load && gen.last;

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (load) begin
                idx_reg <= gen.last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= gen;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/line_ending_normalizer.sv =====
// ----------------------------------------------------------------------------
// line_ending_normalizer
// Rewrites CR, LF, CR LF, LF CR and zero-byte terminators as a set sequence.
// ----------------------------------------------------------------------------
// The input accepts a request whenever the command queue is not full; the
// output side sends one byte per cycle while the output is not stalled. A
// request that causes a line break yields one output byte per terminator byte
// (length saturated at eight) plus one for a passed byte. A four-entry command
// queue sits between the classifier and the expander, so input keeps flowing
// until the queue fills during long terminator runs. Registers: eol_bytes at
// address 0 (64 bits, byte 0 sent first) and the terminator length at address
// 8; write them only while the block is idle.
// ----------------------------------------------------------------------------
module line_ending_normalizer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lenorm_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lenorm_pkg::out_item_t m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    logic [63:0]                  eol_bytes_reg;
    logic [lenorm_pkg::LEN_W-1:0] brk_len_reg;
    logic                         wr_en;
    logic                         q_full, q_push, q_pop, head_valid;
    lenorm_pkg::cmd_t             q_cmd, head_cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eol_bytes_reg <= lenorm_pkg::RESET_EOL_BYTES;
            brk_len_reg   <= lenorm_pkg::RESET_LEN;
        end else if (wr_en) begin
            if (paddr[3] == lenorm_pkg::REG_EOL_BYTES) begin
                eol_bytes_reg <= pwdata;
            end else begin
                brk_len_reg <= pwdata[lenorm_pkg::LEN_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[3] == lenorm_pkg::REG_EOL_LENGTH) begin
            prdata = {{(64 - lenorm_pkg::LEN_W){1'b0}}, brk_len_reg};
        end else begin
            prdata = eol_bytes_reg;
        end
    end

    lenorm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .brk_len    (brk_len_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    lenorm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lenorm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eol_bytes  (eol_bytes_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
